### sv/summed_area_box_sum_core_defines.svh
// Assertion macros for the summed-area box-sum core checker.
// No dependencies; included by the checker file only.
`ifndef SUMMED_AREA_BOX_SUM_CORE_DEFINES_SVH
`define SUMMED_AREA_BOX_SUM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SABS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SABS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sabs_pkg.sv
// Shared types, codes and defaults for the summed-area box-sum core.
// No dependencies.
package sabs_pkg;

    // Default sizes
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_COLUMNS  = 64;
    localparam int DEF_ELEMENT_BITS = 16;

    // Fixed field widths
    localparam int SUM_W    = 28;
    localparam int SIZE_W   = 7;
    localparam int RADIUS_W = 6;
    localparam int QUERY_W  = 6;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 7;
    localparam int STATUS_W = 2;

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_ROW_COUNT     = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_COLUMN_COUNT  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WINDOW_RADIUS = 2'd2;

    // Configuration reset values
    localparam logic [SIZE_W-1:0]   ROW_COUNT_RESET     = 7'd64;
    localparam logic [SIZE_W-1:0]   COLUMN_COUNT_RESET  = 7'd64;
    localparam logic [RADIUS_W-1:0] WINDOW_RADIUS_RESET = 6'd1;

    // One table term: which row/column corner and whether it is subtracted
    typedef struct packed {
        logic use_rb;
        logic use_cb;
        logic subtract;
    } t_term;

    // Term sequence.
    // Load:  T(r,c-1) + T(r-1,c) - T(r-1,c-1)
    // Query: T(r2,c2) - T(r1-1,c2) - T(r2,c1-1) + T(r1-1,c1-1)
    function automatic t_term term_of(input logic action, input logic [1:0] k);
        t_term t;
        t = '{use_rb: 1'b0, use_cb: 1'b0, subtract: 1'b0};
        if (action == ACT_LOAD) begin
            case (k)
                2'd0:    t = '{use_rb: 1'b0, use_cb: 1'b1, subtract: 1'b0};
                2'd1:    t = '{use_rb: 1'b1, use_cb: 1'b0, subtract: 1'b0};
                2'd2:    t = '{use_rb: 1'b1, use_cb: 1'b1, subtract: 1'b1};
                default: t = '{use_rb: 1'b0, use_cb: 1'b0, subtract: 1'b0};
            endcase
        end else begin
            case (k)
                2'd0:    t = '{use_rb: 1'b0, use_cb: 1'b0, subtract: 1'b0};
                2'd1:    t = '{use_rb: 1'b1, use_cb: 1'b0, subtract: 1'b1};
                2'd2:    t = '{use_rb: 1'b0, use_cb: 1'b1, subtract: 1'b1};
                default: t = '{use_rb: 1'b1, use_cb: 1'b1, subtract: 1'b0};
            endcase
        end
        return t;
    endfunction

endpackage

### sv/sabs_prefix_ram.sv
// Prefix-sum table storage: one write port, one registered read port.
// No package dependency.
module sabs_prefix_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 28
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/summed_area_box_sum_core.sv
// Summed-area table box-filter core: sequencer, shared adder and table RAM.
// Depends on sabs_pkg and sabs_prefix_ram.
//
// A transaction is taken when i_start is high and o_busy is low; o_busy stays
// high until the transaction is finished. A transaction goes through a setup
// step, the term reads, a step to fold the last read, a step to write or post
// the result and the idle state in which the next transaction is taken; a
// query rejected with an error status skips the term reads and the fold
// step. The single RAM read port and the single add/subtract unit together
// fold in one table term per cycle (three terms for a load, four for a
// query). A query's result appears on o_block_sum/o_status for exactly one
// cycle with o_done high, in the first cycle o_busy is low again; the
// receiver must take it then, as nothing holds it. Loads produce no result.
// There is no clearing pass after reset.
module summed_area_box_sum_core
    import sabs_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_action,
    input  logic signed [ELEMENT_BITS-1:0] i_element_value,
    input  logic        [QUERY_W-1:0]      i_query_row,
    input  logic        [QUERY_W-1:0]      i_query_column,
    // Result channel
    output logic                           o_done,
    output logic signed [SUM_W-1:0]        o_block_sum,
    output logic        [STATUS_W-1:0]     o_status,
    // Configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic        [CFG_AW-1:0]       i_cfg_addr,
    input  logic        [CFG_DW-1:0]       i_cfg_wr_data
);

    localparam int MAX_DIM = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
    localparam int DIM_W0  = $clog2(MAX_DIM + 1);
    localparam int DIM_W   = (DIM_W0 > SIZE_W) ? DIM_W0 : SIZE_W;
    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_TERM,
        S_LAST,
        S_DONE
    } t_state;

    // Size register clamp: zero acts as one, above the maximum acts as it
    function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int maxv);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > maxv) begin
            return DIM_W'(maxv);
        end
        return DIM_W'(v);
    endfunction

    t_state                    r_state;
    logic                      r_action;
    logic signed [ELEMENT_BITS-1:0] r_elem;
    logic [QUERY_W-1:0]        r_qrow;
    logic [QUERY_W-1:0]        r_qcol;
    logic [DIM_W-1:0]          r_rows;
    logic [DIM_W-1:0]          r_cols;
    logic [RADIUS_W-1:0]       r_radius;
    logic [DIM_W-1:0]          r_load_row;
    logic [DIM_W-1:0]          r_load_col;
    logic                      r_loaded;
    logic [DIM_W-1:0]          r_ra;
    logic [DIM_W-1:0]          r_rb;
    logic [DIM_W-1:0]          r_ca;
    logic [DIM_W-1:0]          r_cb;
    logic                      r_rb_ok;
    logic                      r_cb_ok;
    logic [1:0]                r_k;
    logic                      r_pend_ok;
    logic                      r_pend_sub;
    logic [SUM_W-1:0]          r_acc;
    logic                      r_done;
    logic [SUM_W-1:0]          r_sum;
    logic [STATUS_W-1:0]       r_status;

    logic [SUM_W-1:0]          n_acc;
    logic [SUM_W-1:0]          w_operand;
    logic [SUM_W-1:0]          w_rd_data;
    logic signed [63:0]        w_elem_wide;
    t_term                     w_term;
    logic                      w_term_ok;
    logic                      w_last_term;
    logic [DIM_W-1:0]          w_row;
    logic [DIM_W-1:0]          w_col;
    logic [ADDR_W-1:0]         w_addr;
    logic [DIM_W-1:0]          w_qr;
    logic [DIM_W-1:0]          w_qc;
    logic [DIM_W-1:0]          w_k;
    logic [DIM_W-1:0]          w_r1;
    logic [DIM_W-1:0]          w_r2;
    logic [DIM_W-1:0]          w_c1;
    logic [DIM_W-1:0]          w_c2;
    logic                      w_outside;
    logic                      w_pos_bad;
    logic [DIM_W-1:0]          w_lr;
    logic [DIM_W-1:0]          w_lc;
    logic [DIM_W-1:0]          w_next_col;
    logic [DIM_W-1:0]          w_next_row;

    // Element sign-extended to 64 bits; the low SUM_W bits are used
    assign w_elem_wide = 64'(r_elem);

    // Window bounds, clamped to the matrix edges
    always_comb begin
        w_qr = DIM_W'(r_qrow);
        w_qc = DIM_W'(r_qcol);
        w_k  = DIM_W'(r_radius);
        w_r1 = (w_qr > w_k) ? w_qr - w_k : '0;
        w_c1 = (w_qc > w_k) ? w_qc - w_k : '0;
        w_r2 = (w_qr + w_k < r_rows - DIM_W'(1)) ? w_qr + w_k : r_rows - DIM_W'(1);
        w_c2 = (w_qc + w_k < r_cols - DIM_W'(1)) ? w_qc + w_k : r_cols - DIM_W'(1);
        w_outside = (w_qr >= r_rows) || (w_qc >= r_cols);
    end

    // Load position, restarted when it no longer fits the matrix
    always_comb begin
        w_pos_bad  = (r_load_row >= r_rows) || (r_load_col >= r_cols);
        w_lr       = w_pos_bad ? '0 : r_load_row;
        w_lc       = w_pos_bad ? '0 : r_load_col;
        w_next_col = r_ca + DIM_W'(1);
        w_next_row = r_ra + DIM_W'(1);
    end

    // Term decode and table address; the write in S_DONE uses corner (a,a)
    always_comb begin
        w_term      = term_of(r_action, r_k);
        w_last_term = (r_action == ACT_QUERY) ? (r_k == 2'd3) : (r_k == 2'd2);
        if (r_state == S_TERM) begin
            w_row     = w_term.use_rb ? r_rb : r_ra;
            w_col     = w_term.use_cb ? r_cb : r_ca;
            w_term_ok = (!w_term.use_rb || r_rb_ok) && (!w_term.use_cb || r_cb_ok);
        end else begin
            w_row     = r_ra;
            w_col     = r_ca;
            w_term_ok = 1'b1;
        end
        if (w_term_ok) begin
            w_addr = ADDR_W'(w_row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(w_col);
        end else begin
            w_addr = '0;
        end
    end

    // Shared add/subtract unit
    always_comb begin
        w_operand = r_pend_ok ? w_rd_data : '0;
        n_acc     = r_pend_sub ? r_acc - w_operand : r_acc + w_operand;
    end

    sabs_prefix_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SUM_W)
    ) u_prefix_ram (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == S_DONE) && (r_action == ACT_LOAD)),
        .i_wr_addr (w_addr),
        .i_wr_data (r_acc),
        .i_rd_en   (r_state == S_TERM),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rows     <= clamp_size(ROW_COUNT_RESET, MAX_ROWS);
            r_cols     <= clamp_size(COLUMN_COUNT_RESET, MAX_COLUMNS);
            r_radius   <= WINDOW_RADIUS_RESET;
            r_load_row <= '0;
            r_load_col <= '0;
            r_loaded   <= 1'b0;
            r_k        <= '0;
            r_pend_ok  <= 1'b0;
            r_pend_sub <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_action <= i_action;
                        r_elem   <= i_element_value;
                        r_qrow   <= i_query_row;
                        r_qcol   <= i_query_column;
                        r_state  <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_k       <= '0;
                    r_pend_ok <= 1'b0;
                    if (r_action == ACT_QUERY) begin
                        r_acc   <= '0;
                        r_ra    <= w_r2;
                        r_rb    <= w_r1 - DIM_W'(1);
                        r_rb_ok <= (w_r1 != '0);
                        r_ca    <= w_c2;
                        r_cb    <= w_c1 - DIM_W'(1);
                        r_cb_ok <= (w_c1 != '0);
                        if (!r_loaded) begin
                            r_status <= STATUS_NOT_LOADED;
                            r_state  <= S_DONE;
                        end else if (w_outside) begin
                            r_status <= STATUS_OUTSIDE;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= STATUS_OK;
                            r_state  <= S_TERM;
                        end
                    end else begin
                        r_acc   <= w_elem_wide[SUM_W-1:0];
                        r_ra    <= w_lr;
                        r_rb    <= w_lr - DIM_W'(1);
                        r_rb_ok <= (w_lr != '0);
                        r_ca    <= w_lc;
                        r_cb    <= w_lc - DIM_W'(1);
                        r_cb_ok <= (w_lc != '0);
                        if ((w_lr == '0) && (w_lc == '0)) begin
                            r_loaded <= 1'b0;
                        end
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    // read of term k goes out; term k-1 data is folded in
                    if (r_k != '0) begin
                        r_acc <= n_acc;
                    end
                    r_pend_ok  <= w_term_ok;
                    r_pend_sub <= w_term.subtract;
                    r_k        <= r_k + 2'd1;
                    if (w_last_term) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_acc   <= n_acc;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_action == ACT_QUERY) begin
                        r_done <= 1'b1;
                        r_sum  <= r_acc;
                    end else begin
                        // advance the row-major load position
                        if (w_next_col >= r_cols) begin
                            r_load_col <= '0;
                            if (w_next_row >= r_rows) begin
                                r_load_row <= '0;
                                r_loaded   <= 1'b1;
                            end else begin
                                r_load_row <= w_next_row;
                            end
                        end else begin
                            r_load_col <= w_next_col;
                            r_load_row <= r_ra;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Configuration writes; a size change restarts loading
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_ROW_COUNT: begin
                        r_rows     <= clamp_size(i_cfg_wr_data, MAX_ROWS);
                        r_load_row <= '0;
                        r_load_col <= '0;
                        r_loaded   <= 1'b0;
                    end
                    CFG_COLUMN_COUNT: begin
                        r_cols     <= clamp_size(i_cfg_wr_data, MAX_COLUMNS);
                        r_load_row <= '0;
                        r_load_col <= '0;
                        r_loaded   <= 1'b0;
                    end
                    CFG_WINDOW_RADIUS: begin
                        r_radius <= i_cfg_wr_data[RADIUS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_block_sum = signed'(r_sum);
    assign o_status    = r_status;

endmodule

### sv/sabs_checker.sv
// Port-level checker for the summed-area box-sum core, bound to the top level.
// Depends on sabs_pkg and summed_area_box_sum_core_defines.svh.
`include "summed_area_box_sum_core_defines.svh"

module sabs_checker
    import sabs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                i_busy,
    input logic                i_done,
    input logic [SUM_W-1:0]    i_block_sum,
    input logic [STATUS_W-1:0] i_status
);

    // An accepted transaction keeps the block busy
    `SABS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy, "start not taken")

    // A result is only shown once the block has gone idle after working
    `SABS_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, i_done, !i_busy && $past(i_busy), "stray result")

    // Status codes are limited to the defined set
    `SABS_ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, i_done, i_status <= STATUS_OUTSIDE, "bad status")

    // An error result carries a zero sum
    `SABS_ASSERT_IMPLY(a_error_zero, i_clk, i_rst_n, i_done && (i_status != STATUS_OK), i_block_sum == '0, "error with sum")

endmodule

bind summed_area_box_sum_core sabs_checker u_sabs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .i_busy      (o_busy),
    .i_done      (o_done),
    .i_block_sum (o_block_sum),
    .i_status    (o_status)
);
